/* hw/rtl/eat_pkg.sv */
// Extent allocation table: shared types, constants and codes.
// No dependencies; used by the top level and the round-up unit.
package eat_pkg;

    localparam int unsigned MAX_ENTRIES = 1024;
    localparam int unsigned IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned OFF_W       = 48;
    localparam int unsigned BS_W        = 32;
    localparam int unsigned RND_W       = OFF_W + 1;   // rounded value may pass 48 bits
    localparam int unsigned SUM_W       = OFF_W + 2;   // start plus rounded size
    localparam int unsigned RND_STEPS   = OFF_W;       // one dividend bit per cycle
    localparam int unsigned RND_CNT_W   = $clog2(RND_STEPS + 1);
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [BS_W-1:0] BLOCK_SIZE_RESET = BS_W'(128 * 1024);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OFFSET = 2'd2;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_FIND    = 2'd2,
        ACT_REALLOC = 2'd3
    } eat_action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } eat_status_t;

    typedef struct packed {
        eat_action_t        action;
        logic [OFF_W-1:0]   size;
        logic [OFF_W-1:0]   offset;
    } eat_in_t;

    typedef struct packed {
        eat_status_t        status;
        logic [OFF_W-1:0]   result_offset;
        logic [OFF_W-1:0]   reserved_size;
        logic               copy_needed;
        logic [OFF_W-1:0]   copy_from;
        logic [OFF_W-1:0]   copy_size;
    } eat_out_t;

    // One table entry as stored in memory
    typedef struct packed {
        logic [OFF_W-1:0]   start;
        logic [OFF_W-1:0]   reserved;
        logic               deleted;
    } eat_entry_t;

    // Rounding unit request and response
    typedef struct packed {
        logic               go;
        logic [OFF_W-1:0]   value;
    } eat_rnd_req_t;

    typedef struct packed {
        logic               done;
        logic [RND_W-1:0]   value;
    } eat_rnd_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_RS_GO,
        S_RS_WAIT,
        S_PLACE,
        S_RM_GO,
        S_RM_WAIT,
        S_CHECK,
        S_WR_NEW,
        S_WR_OLD,
        S_DONE
    } eat_state_t;

endpackage

/* hw/rtl/extent_allocation_table.sv */
// Extent allocation table top level: sequencer, table scans, config registers.
// Depends on eat_pkg, eat_ram and eat_rnd.
//
//  channel | ports                              | direction | word
//  input   | s_valid s_ready s_data             | in        | eat_in_t
//  result  | m_valid m_ready m_data             | out       | eat_out_t
//  config  | cfg_valid cfg_ready cfg_index/data | in        | index + 48-bit value
//
// Find and free scan the table one entry per cycle through the one read port of
// the table memory. Alloc rounds the size up, then scans back for the last live
// entry, with a second pass of the round-up unit when no live entry is left.
// Realloc that moves scans the table twice.
// Reset clears the entry count and control state and restores the config registers;
// the memory needs no clearing. A new word is taken while a finished result still waits on m_ready.
module extent_allocation_table (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  eat_pkg::eat_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output eat_pkg::eat_out_t                 m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [eat_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [eat_pkg::OFF_W-1:0]         cfg_data
);

    eat_pkg::eat_state_t            state_reg, state_next;
    eat_pkg::eat_status_t           status_reg, status_next;
    logic [eat_pkg::CNT_W-1:0]      count_reg;
    logic [eat_pkg::BS_W-1:0]       bs_reg;
    logic [eat_pkg::OFF_W-1:0]      minoff_reg;
    logic [eat_pkg::OFF_W-1:0]      maxoff_reg;
    eat_pkg::eat_in_t               in_reg;
    logic [eat_pkg::CNT_W-1:0]      scan_reg;
    logic                           pend_reg;
    logic [eat_pkg::IDX_W-1:0]      pend_idx_reg;
    logic [eat_pkg::IDX_W-1:0]      hit_idx_reg;
    logic [eat_pkg::OFF_W-1:0]      hit_rsv_reg;
    logic [eat_pkg::RND_W-1:0]      place_reg;
    logic [eat_pkg::RND_W-1:0]      rnd_size_reg;
    logic                           m_valid_reg;
    eat_pkg::eat_out_t              m_data_reg;

    eat_pkg::eat_entry_t            rd_entry;
    eat_pkg::eat_entry_t            wr_entry;
    logic                           ram_we;
    logic [eat_pkg::IDX_W-1:0]      ram_waddr;
    logic [eat_pkg::IDX_W-1:0]      ram_raddr;
    eat_pkg::eat_rnd_req_t          rnd_req;
    eat_pkg::eat_rnd_rsp_t          rnd_rsp;
    eat_pkg::eat_out_t              out_word;

    logic                           s_accept;
    logic                           full;
    logic                           find_hit;
    logic                           place_hit;
    logic                           find_more;
    logic                           place_more;
    logic                           issue;
    logic [eat_pkg::CNT_W-1:0]      scan_dec;
    logic [eat_pkg::SUM_W-1:0]      end_sum;
    logic                           moved;
    logic                           m_load;

    eat_ram #(
        .WIDTH ($bits(eat_pkg::eat_entry_t)),
        .DEPTH (eat_pkg::MAX_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    eat_rnd u_rnd (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .gran_size  (bs_reg),
        .req        (rnd_req),
        .rsp        (rnd_rsp)
    );

    // Scan status
    assign s_accept   = s_valid && s_ready;
    assign full       = count_reg >= eat_pkg::CNT_W'(eat_pkg::MAX_ENTRIES);
    assign find_hit   = pend_reg && !rd_entry.deleted && (rd_entry.start == in_reg.offset);
    assign place_hit  = pend_reg && !rd_entry.deleted;
    assign find_more  = scan_reg < count_reg;
    assign place_more = scan_reg != '0;
    assign scan_dec   = scan_reg - 1'b1;
    assign end_sum    = eat_pkg::SUM_W'(place_reg) + eat_pkg::SUM_W'(rnd_size_reg);
    assign moved      = (in_reg.action == eat_pkg::ACT_REALLOC) && (hit_rsv_reg < in_reg.size);
    assign m_load     = (state_reg == eat_pkg::S_DONE) && (!m_valid_reg || m_ready);

    // Next state
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        case (state_reg)
            eat_pkg::S_IDLE: begin
                if (s_accept) begin
                    status_next = eat_pkg::STAT_OK;
                    if (s_data.action == eat_pkg::ACT_ALLOC) begin
                        if (full) begin
                            status_next = eat_pkg::STAT_NO_SPACE;
                            state_next  = eat_pkg::S_DONE;
                        end else begin
                            state_next = eat_pkg::S_RS_GO;
                        end
                    end else begin
                        state_next = eat_pkg::S_FIND;
                    end
                end
            end
            eat_pkg::S_FIND: begin
                if (find_hit) begin
                    case (in_reg.action)
                        eat_pkg::ACT_FREE: state_next = eat_pkg::S_WR_OLD;
                        eat_pkg::ACT_REALLOC: begin
                            if (rd_entry.reserved >= in_reg.size) begin
                                state_next = eat_pkg::S_DONE;
                            end else if (full) begin
                                status_next = eat_pkg::STAT_NO_SPACE;
                                state_next  = eat_pkg::S_DONE;
                            end else begin
                                state_next = eat_pkg::S_RS_GO;
                            end
                        end
                        default: state_next = eat_pkg::S_DONE;
                    endcase
                end else if (!pend_reg && !find_more) begin
                    status_next = eat_pkg::STAT_NOT_FOUND;
                    state_next  = eat_pkg::S_DONE;
                end
            end
            eat_pkg::S_RS_GO: state_next = eat_pkg::S_RS_WAIT;
            eat_pkg::S_RS_WAIT: begin
                if (rnd_rsp.done) begin
                    state_next = eat_pkg::S_PLACE;
                end
            end
            eat_pkg::S_PLACE: begin
                if (place_hit) begin
                    state_next = eat_pkg::S_CHECK;
                end else if (!pend_reg && !place_more) begin
                    state_next = eat_pkg::S_RM_GO;
                end
            end
            eat_pkg::S_RM_GO: state_next = eat_pkg::S_RM_WAIT;
            eat_pkg::S_RM_WAIT: begin
                if (rnd_rsp.done) begin
                    state_next = eat_pkg::S_CHECK;
                end
            end
            eat_pkg::S_CHECK: begin
                if (end_sum > eat_pkg::SUM_W'(maxoff_reg)) begin
                    status_next = eat_pkg::STAT_NO_SPACE;
                    state_next  = eat_pkg::S_DONE;
                end else begin
                    state_next = eat_pkg::S_WR_NEW;
                end
            end
            eat_pkg::S_WR_NEW: begin
                state_next = (in_reg.action == eat_pkg::ACT_REALLOC) ?
                             eat_pkg::S_WR_OLD : eat_pkg::S_DONE;
            end
            eat_pkg::S_WR_OLD: state_next = eat_pkg::S_DONE;
            eat_pkg::S_DONE: begin
                if (m_load) begin
                    state_next = eat_pkg::S_IDLE;
                end
            end
            default: state_next = eat_pkg::S_IDLE;
        endcase
    end

    // Outputs: memory access, round-up requests, handshake
    always_comb begin
        s_ready       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[eat_pkg::IDX_W-1:0];
        wr_entry      = '0;
        ram_raddr     = scan_reg[eat_pkg::IDX_W-1:0];
        issue         = 1'b0;
        rnd_req.go    = 1'b0;
        rnd_req.value = in_reg.size;
        case (state_reg)
            eat_pkg::S_IDLE: s_ready = 1'b1;
            eat_pkg::S_FIND: issue = find_more && !find_hit;
            eat_pkg::S_RS_GO: rnd_req.go = 1'b1;
            eat_pkg::S_PLACE: begin
                ram_raddr = scan_dec[eat_pkg::IDX_W-1:0];
                issue     = place_more && !place_hit;
            end
            eat_pkg::S_RM_GO: begin
                rnd_req.go    = 1'b1;
                rnd_req.value = minoff_reg;
            end
            eat_pkg::S_WR_NEW: begin
                ram_we            = 1'b1;
                wr_entry.start    = place_reg[eat_pkg::OFF_W-1:0];
                wr_entry.reserved = rnd_size_reg[eat_pkg::OFF_W-1:0];
                wr_entry.deleted  = 1'b0;
            end
            eat_pkg::S_WR_OLD: begin
                ram_we            = 1'b1;
                ram_waddr         = hit_idx_reg;
                wr_entry.start    = in_reg.offset;
                wr_entry.reserved = hit_rsv_reg;
                wr_entry.deleted  = 1'b1;
            end
            default: ;
        endcase
    end

    // Result word
    always_comb begin
        out_word        = '0;
        out_word.status = status_reg;
        if (status_reg == eat_pkg::STAT_OK) begin
            if (in_reg.action == eat_pkg::ACT_ALLOC || moved) begin
                out_word.result_offset = place_reg[eat_pkg::OFF_W-1:0];
                out_word.reserved_size = rnd_size_reg[eat_pkg::OFF_W-1:0];
            end else begin
                out_word.result_offset = in_reg.offset;
                out_word.reserved_size = hit_rsv_reg;
            end
            if (moved) begin
                out_word.copy_needed = 1'b1;
                out_word.copy_from   = in_reg.offset;
                out_word.copy_size   = hit_rsv_reg;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= eat_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            bs_reg      <= eat_pkg::BLOCK_SIZE_RESET;
            minoff_reg  <= '0;
            maxoff_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (ram_we && state_reg == eat_pkg::S_WR_NEW) begin
                count_reg <= count_reg + 1'b1;
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            pend_reg <= issue;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    eat_pkg::REG_BLOCK_SIZE: bs_reg     <= cfg_data[eat_pkg::BS_W-1:0];
                    eat_pkg::REG_MIN_OFFSET: minoff_reg <= cfg_data;
                    eat_pkg::REG_MAX_OFFSET: maxoff_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (s_accept) begin
            in_reg <= s_data;
        end
        if (issue) begin
            pend_idx_reg <= ram_raddr;
        end
        case (state_reg)
            eat_pkg::S_IDLE: scan_reg <= '0;
            eat_pkg::S_FIND: begin
                if (issue) begin
                    scan_reg <= scan_reg + 1'b1;
                end
                if (find_hit) begin
                    hit_idx_reg <= pend_idx_reg;
                    hit_rsv_reg <= rd_entry.reserved;
                end
            end
            eat_pkg::S_RS_WAIT: begin
                scan_reg <= count_reg;
                if (rnd_rsp.done) begin
                    rnd_size_reg <= rnd_rsp.value;
                end
            end
            eat_pkg::S_PLACE: begin
                if (issue) begin
                    scan_reg <= scan_dec;
                end
                if (place_hit) begin
                    place_reg <= eat_pkg::RND_W'(rd_entry.start) +
                                 eat_pkg::RND_W'(rd_entry.reserved);
                end
            end
            eat_pkg::S_RM_WAIT: begin
                if (rnd_rsp.done) begin
                    place_reg <= rnd_rsp.value;
                end
            end
            default: ;
        endcase
        if (m_load) begin
            m_data_reg <= out_word;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Table never grows past its capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= eat_pkg::CNT_W'(eat_pkg::MAX_ENTRIES))
        else $error("entry count past capacity");

    // Appending a new entry bumps the count by one
    a_append_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == eat_pkg::S_WR_NEW) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not advance entry count");

    // Failed results carry no offset, no size and no copy request
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != eat_pkg::STAT_OK) |->
        (m_data.result_offset == '0 && m_data.reserved_size == '0 && !m_data.copy_needed))
        else $error("failed result with nonzero fields");

    // Table is never written while a new word is taken
    a_no_wr_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !s_accept)
        else $error("table write during accept");

endmodule

/* hw/rtl/eat_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module eat_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/eat_rnd.sv */
// Round-up unit: value rounded up to a multiple of the block size.
// Bit-serial restoring remainder, one bit per cycle. Depends on eat_pkg.
module eat_rnd (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [eat_pkg::BS_W-1:0]      gran_size,
    input  eat_pkg::eat_rnd_req_t         req,
    output eat_pkg::eat_rnd_rsp_t         rsp
);

    logic                               busy_reg;
    logic [eat_pkg::RND_CNT_W-1:0]      cnt_reg;
    logic [eat_pkg::OFF_W-1:0]          v_reg;
    logic [eat_pkg::OFF_W-1:0]          sh_reg;
    logic [eat_pkg::BS_W-1:0]           rem_reg;
    logic [eat_pkg::BS_W-1:0]           bs_reg;
    logic [eat_pkg::BS_W:0]             rem_sh;
    logic [eat_pkg::BS_W-1:0]           rem_next;
    logic [eat_pkg::BS_W-1:0]           pad;

    // One remainder step
    always_comb begin
        rem_sh = {rem_reg, sh_reg[eat_pkg::OFF_W-1]};
        if (rem_sh >= {1'b0, bs_reg}) begin
            rem_next = eat_pkg::BS_W'(rem_sh - {1'b0, bs_reg});
        end else begin
            rem_next = rem_sh[eat_pkg::BS_W-1:0];
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.go) begin
            busy_reg <= 1'b1;
            cnt_reg  <= eat_pkg::RND_CNT_W'(eat_pkg::RND_STEPS);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (req.go) begin
            v_reg   <= req.value;
            sh_reg  <= req.value;
            rem_reg <= '0;
            bs_reg  <= (gran_size == '0) ? eat_pkg::BS_W'(1) : gran_size;
        end else if (busy_reg && cnt_reg != '0) begin
            sh_reg  <= {sh_reg[eat_pkg::OFF_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    // Result: v plus the distance to the next multiple
    assign pad       = (rem_reg != '0) ? (bs_reg - rem_reg) : '0;
    assign rsp.done  = busy_reg && (cnt_reg == '0);
    assign rsp.value = {1'b0, v_reg} + eat_pkg::RND_W'(pad);

endmodule
